### src/dtq_pkg.sv
`timescale 1ns / 1ps
package dtq_pkg;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int TIME_BITS_DEF = 48;
	localparam int RESULT_LIMIT = 16;
	localparam int HANDLE_W = 16;
	localparam int DELAY_W = 32;
	localparam int OUT_TIME_W = 48;
	localparam int ORDER_W = 32;

	typedef enum logic [1:0] {
		KIND_ACCEPTED = 2'd0,
		KIND_REJECTED = 2'd1,
		KIND_FIRED    = 2'd2
	} kind_t;

	localparam logic ACT_SCHEDULE = 1'b0;
	localparam logic ACT_TICK     = 1'b1;
endpackage

### src/deadline_timer_queue_top.sv
`timescale 1ns / 1ps
// Software timer queue. A schedule item (action 0) always yields one result,
// accepted or rejected, valid in the cycle after the item is taken. A tick item
// (action 1) advances the millisecond counter and fires due timers, earliest
// deadline first and ties in insertion order, up to 16 per tick. Each search
// reads the live slot memory one entry per cycle. A firing costs that search,
// a decide step, a move of the last entry into the freed slot in a read step
// and a write step, and a staging step that waits for the output to drain. A
// tick closes with a search and a decide step, which is all that a tick with
// nothing due does. The slot memory needs no clearing after reset; a fill
// count marks the live entries. One item is worked at a time. A firing is held
// in the output register until the next search shows whether it is the last
// one of the tick, and no new item is taken until the final result has been
// taken.
module deadline_timer_queue_top #(
	parameter int QUEUE_DEPTH = dtq_pkg::QUEUE_DEPTH_DEF,
	parameter int TIME_BITS = dtq_pkg::TIME_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// tdata: delay_ms [31:0], handle [47:32]
	input  logic [47:0]  s_tdata,
	// tuser: action
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// tdata: kind [1:0], fired_handle [17:2], deadline [65:18], late_ms [113:66], pad
	output logic [119:0] m_tdata,
	output logic         m_tlast
);
	import dtq_pkg::*;

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int FCNT_W = $clog2(RESULT_LIMIT + 1);
	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_DECIDE, ST_MOVE_RD, ST_MOVE_WR, ST_OUT
	} state_t;

	// result packing, times cut to the output width
	function automatic logic [119:0] pack_result(kind_t k, logic [HANDLE_W-1:0] h,
			logic [TIME_BITS-1:0] dl, logic [TIME_BITS-1:0] late);
		return {6'd0, OUT_TIME_W'({{OUT_TIME_W{1'b0}}, late}),
			OUT_TIME_W'({{OUT_TIME_W{1'b0}}, dl}), h, k};
	endfunction

	// slot memory: deadline, handle, order
	localparam int ENT_W = TIME_BITS + HANDLE_W + ORDER_W;
	logic [ENT_W-1:0] mem [QUEUE_DEPTH];
	logic [ENT_W-1:0] rd_data;
	logic [IDX_W-1:0] rd_addr, wr_addr;
	logic [ENT_W-1:0] wr_data;
	logic             wr_en;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_data <= mem[rd_addr];
	end

	state_t              state_q;
	logic [TIME_BITS-1:0] now_q;
	logic [CNT_W-1:0]    used_q;
	logic [ORDER_W-1:0]  serial_q;
	logic [CNT_W-1:0]    scan_q;      // next address issued
	logic                rd_vld_q;
	logic [IDX_W-1:0]    rd_idx_q;
	logic [IDX_W-1:0]    best_idx_q;
	logic [TIME_BITS-1:0] best_dl_q;
	logic [HANDLE_W-1:0] best_hnd_q;
	logic [ORDER_W-1:0]  best_age_q;
	logic                best_vld_q;
	logic [FCNT_W-1:0]   fired_q;
	logic                stage_q;     // a firing waits in the output register

	logic [TIME_BITS-1:0] rd_dl;
	logic [HANDLE_W-1:0]  rd_hnd;
	logic [ORDER_W-1:0]   rd_age;
	logic                 better;
	assign rd_dl  = rd_data[TIME_BITS-1:0];
	assign rd_hnd = rd_data[TIME_BITS +: HANDLE_W];
	assign rd_age = serial_q - rd_data[TIME_BITS+HANDLE_W +: ORDER_W];
	assign better = !best_vld_q || (rd_dl < best_dl_q) ||
		(rd_dl == best_dl_q && rd_age > best_age_q);

	// schedule deadline, saturated
	logic [TIME_BITS:0]   dl_sum;
	logic [TIME_BITS-1:0] dl_sat;
	assign dl_sum = {1'b0, now_q} + {{(TIME_BITS+1-DELAY_W){1'b0}}, s_tdata[31:0]};
	assign dl_sat = dl_sum[TIME_BITS] ? TIME_MAX : dl_sum[TIME_BITS-1:0];

	logic sched_ok;
	assign sched_ok = s_tdata[47:32] != '0 && used_q < CNT_W'(QUEUE_DEPTH);

	logic [IDX_W-1:0] last_idx;
	assign last_idx = IDX_W'(used_q - CNT_W'(1));

	assign s_tready = (state_q == ST_IDLE) && !m_tvalid;

	// result becomes visible: schedule answer or release of a staged firing
	logic out_set;
	assign out_set = (state_q == ST_IDLE && s_tvalid && s_tready &&
		s_tuser == ACT_SCHEDULE) || (state_q == ST_DECIDE && stage_q);

	always_comb begin
		rd_addr = scan_q[IDX_W-1:0];
		if (state_q == ST_MOVE_RD) rd_addr = last_idx;
		wr_en = 1'b0;
		wr_addr = best_idx_q;
		wr_data = rd_data;
		if (state_q == ST_IDLE && s_tvalid && s_tready && s_tuser == ACT_SCHEDULE &&
			sched_ok) begin
			wr_en = 1'b1;
			wr_addr = used_q[IDX_W-1:0];
			wr_data = {serial_q, s_tdata[47:32], dl_sat};
		end else if (state_q == ST_MOVE_WR) begin
			wr_en = 1'b1;
		end
	end

	// control and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			now_q <= '0;
			used_q <= '0;
			serial_q <= '0;
			scan_q <= '0;
			rd_vld_q <= 1'b0;
			best_vld_q <= 1'b0;
			fired_q <= '0;
			stage_q <= 1'b0;
			m_tvalid <= 1'b0;
			m_tlast <= 1'b0;
			m_tdata <= '0;
			rd_idx_q <= '0;
			best_idx_q <= '0;
			best_dl_q <= '0;
			best_hnd_q <= '0;
			best_age_q <= '0;
		end else begin
			if (out_set) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						if (s_tuser == ACT_SCHEDULE) begin
							m_tlast <= 1'b1;
							if (sched_ok) begin
								m_tdata <= pack_result(KIND_ACCEPTED, s_tdata[47:32],
									dl_sat, '0);
								used_q <= used_q + CNT_W'(1);
								serial_q <= serial_q + ORDER_W'(1);
							end else begin
								m_tdata <= pack_result(KIND_REJECTED, s_tdata[47:32],
									dl_sat, '0);
							end
						end else begin
							if (now_q != TIME_MAX) now_q <= now_q + TIME_BITS'(1);
							fired_q <= '0;
							scan_q <= '0;
							rd_vld_q <= 1'b0;
							best_vld_q <= 1'b0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// one entry issued and one compared per cycle
					if (rd_vld_q && better) begin
						best_vld_q <= 1'b1;
						best_idx_q <= rd_idx_q;
						best_dl_q <= rd_dl;
						best_hnd_q <= rd_hnd;
						best_age_q <= rd_age;
					end
					if (scan_q < used_q) begin
						rd_vld_q <= 1'b1;
						rd_idx_q <= scan_q[IDX_W-1:0];
						scan_q <= scan_q + CNT_W'(1);
					end else begin
						rd_vld_q <= 1'b0;
						if (!rd_vld_q) state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					// another firing due: the staged one is not the last
					if (best_vld_q && best_dl_q < now_q && fired_q < FCNT_W'(RESULT_LIMIT)) begin
						state_q <= ST_MOVE_RD;
					end else begin
						state_q <= ST_IDLE;
						if (stage_q) begin
							m_tlast <= 1'b1;
							stage_q <= 1'b0;
						end
					end
				end
				ST_MOVE_RD: state_q <= ST_MOVE_WR;
				ST_MOVE_WR: begin
					used_q <= used_q - CNT_W'(1);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					// stage this firing once the previous one has left
					if (!m_tvalid || m_tready) begin
						m_tdata <= pack_result(KIND_FIRED, best_hnd_q, best_dl_q,
							now_q - best_dl_q);
						m_tlast <= 1'b0;
						stage_q <= 1'b1;
						fired_q <= fired_q + FCNT_W'(1);
						scan_q <= '0;
						rd_vld_q <= 1'b0;
						best_vld_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// assertions
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(QUEUE_DEPTH)) else $error("used count overflow");
	a_busy_noready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !s_tready) else $error("ready while busy");
	a_fire_limit: assert property (@(posedge clk) disable iff (!arst_n)
		fired_q <= FCNT_W'(RESULT_LIMIT)) else $error("too many firings");
	a_now_mono: assert property (@(posedge clk) disable iff (!arst_n)
		now_q >= $past(now_q)) else $error("time went back");
endmodule
